// ===== rtl/core/iplpr_pkg.sv =====
// Package for the IPv4 longest prefix router.
// Holds the route word layout and the result status codes; depends on nothing.
package iplpr_pkg;

    localparam logic [1:0] STAT_FORWARDED = 2'd0;
    localparam logic [1:0] STAT_EXPIRED   = 2'd1;
    localparam logic [1:0] STAT_NO_ROUTE  = 2'd2;
    localparam logic [1:0] STAT_BAD_IFACE = 2'd3;

    localparam logic [5:0] MAX_PREFIX_LEN = 6'd32;
    localparam logic [4:0] IFACE_COUNT_RESET = 5'd4;

    typedef struct packed {
        logic [31:0] prefix;
        logic [5:0]  length;
        logic        has_hop;
        logic [31:0] hop;
        logic [3:0]  iface;
    } t_route;

endpackage

// ===== rtl/core/ipv4_longest_prefix_router.sv =====
// Top level of the IPv4 longest prefix router: route table RAM and scan sequencer.
// Depends on iplpr_pkg and iplpr_ram.
//
//   Channel   Direction  Handshake                  Payload
//   in        input      i_in_valid / o_in_ready    action, dest_ip, ttl_in, add_prefix, route_*
//   out       output     o_out_valid / i_out_ready  status, egress_interface, forward_to_ip, ttl_out
//   cfg       input      i_cfg_we                   i_cfg_wdata (interface_count)
//
// An add word is written while the block stays in S_IDLE. A forward word goes through
// S_SCAN, S_DRAIN and S_FINISH, the match unit walking the single RAM read port one route
// per cycle. An expired forward, or a forward into an empty table, skips S_SCAN and S_DRAIN.
// Reset clears the route count and sets interface_count to 4; no clearing pass is needed.
// A finished result waits in the output register; the block holds until it is taken.
module ipv4_longest_prefix_router
    import iplpr_pkg::*;
#(
    parameter int TABLE_DEPTH    = 64,
    parameter int MAX_INTERFACES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_action,
    input  logic [31:0] i_dest_ip,
    input  logic [7:0]  i_ttl_in,
    input  logic [31:0] i_add_prefix,
    input  logic [5:0]  i_route_length,
    input  logic        i_route_has_hop,
    input  logic [31:0] i_route_next_hop,
    input  logic [3:0]  i_route_interface,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic [3:0]  o_egress_interface,
    output logic [31:0] o_forward_to_ip,
    output logic [7:0]  o_ttl_out,
    input  logic        i_cfg_we,
    input  logic [4:0]  i_cfg_wdata
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_DEPTH);
    localparam logic [31:0] IFACE_LIMIT = 32'(MAX_INTERFACES);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_DRAIN  = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    logic [1:0]    r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [AW-1:0] r_addr, n_addr;
    logic          r_pend, n_pend;
    logic [4:0]    r_iface_count;
    logic [31:0]   r_dest, n_dest;
    logic [7:0]    r_ttl, n_ttl;
    logic          r_expired, n_expired;
    logic          r_found, n_found;
    t_route        r_best, n_best;
    logic          r_out_valid, n_out_valid;
    logic [1:0]    r_status, n_status;
    logic [3:0]    r_egress, n_egress;
    logic [31:0]   r_fwd_ip, n_fwd_ip;
    logic [7:0]    r_ttl_out, n_ttl_out;

    logic   w_accept;
    logic   w_we;
    logic   w_re;
    t_route w_wr_route;
    t_route w_rd_route;
    logic [31:0] w_mask;
    logic   w_match;
    logic   w_iface_ok;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_we       = w_accept && !i_action && (r_count != FULL_COUNT);
    assign w_re       = (r_state == S_SCAN);

    always_comb begin
        w_wr_route.prefix  = i_add_prefix;
        w_wr_route.length  = (i_route_length > MAX_PREFIX_LEN) ? MAX_PREFIX_LEN
                                                               : i_route_length;
        w_wr_route.has_hop = i_route_has_hop;
        w_wr_route.hop     = i_route_next_hop;
        w_wr_route.iface   = i_route_interface;
    end

    iplpr_ram #(
        .WIDTH ($bits(t_route)),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (w_wr_route),
        .i_re    (w_re),
        .i_raddr (r_addr),
        .o_rdata (w_rd_route)
    );

    assign w_mask  = ~(32'hFFFF_FFFF >> w_rd_route.length);
    assign w_match = ((r_dest ^ w_rd_route.prefix) & w_mask) == 32'd0;
    assign w_iface_ok = ({1'b0, r_best.iface} < r_iface_count)
                     && ({28'd0, r_best.iface} < IFACE_LIMIT);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_addr      = r_addr;
        n_pend      = 1'b0;
        n_dest      = r_dest;
        n_ttl       = r_ttl;
        n_expired   = r_expired;
        n_found     = r_found;
        n_best      = r_best;
        n_out_valid = r_out_valid;
        n_status    = r_status;
        n_egress    = r_egress;
        n_fwd_ip    = r_fwd_ip;
        n_ttl_out   = r_ttl_out;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        if (r_pend && w_match && (!r_found || (w_rd_route.length > r_best.length))) begin
            n_found = 1'b1;
            n_best  = w_rd_route;
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (!i_action) begin
                        if (w_we) begin
                            n_count = r_count + CW'(1);
                        end
                    end else begin
                        n_dest    = i_dest_ip;
                        n_ttl     = i_ttl_in - 8'd1;
                        n_expired = (i_ttl_in <= 8'd1);
                        n_found   = 1'b0;
                        n_addr    = '0;
                        if ((i_ttl_in <= 8'd1) || (r_count == '0)) begin
                            n_state = S_FINISH;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end
                end
            end
            S_SCAN: begin
                n_pend = 1'b1;
                if (CW'(r_addr) == r_count - CW'(1)) begin
                    n_state = S_DRAIN;
                end else begin
                    n_addr = r_addr + AW'(1);
                end
            end
            S_DRAIN: begin
                n_state = S_FINISH;
            end
            S_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                    if (r_expired) begin
                        n_status  = STAT_EXPIRED;
                        n_egress  = 4'd0;
                        n_fwd_ip  = 32'd0;
                        n_ttl_out = 8'd0;
                    end else if (!r_found) begin
                        n_status  = STAT_NO_ROUTE;
                        n_egress  = 4'd0;
                        n_fwd_ip  = 32'd0;
                        n_ttl_out = r_ttl;
                    end else begin
                        n_status  = w_iface_ok ? STAT_FORWARDED : STAT_BAD_IFACE;
                        n_egress  = r_best.iface;
                        n_fwd_ip  = r_best.has_hop ? r_best.hop : r_dest;
                        n_ttl_out = r_ttl;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_count       <= '0;
            r_pend        <= 1'b0;
            r_out_valid   <= 1'b0;
            r_iface_count <= IFACE_COUNT_RESET;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_iface_count <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr    <= n_addr;
        r_dest    <= n_dest;
        r_ttl     <= n_ttl;
        r_expired <= n_expired;
        r_found   <= n_found;
        r_best    <= n_best;
        r_status  <= n_status;
        r_egress  <= n_egress;
        r_fwd_ip  <= n_fwd_ip;
        r_ttl_out <= n_ttl_out;
    end

    assign o_out_valid        = r_out_valid;
    assign o_status           = r_status;
    assign o_egress_interface = r_egress;
    assign o_forward_to_ip    = r_fwd_ip;
    assign o_ttl_out          = r_ttl_out;

endmodule

// ===== rtl/core/iplpr_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Used for the route table; depends on nothing.
module iplpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/iplpr_checker.sv =====
// Port-level checker for the IPv4 longest prefix router, bound to the top level.
// Depends on iplpr_pkg and ipv4_longest_prefix_router.
module iplpr_checker
    import iplpr_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        i_action,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  o_status,
    input logic [3:0]  o_egress_interface,
    input logic [31:0] o_forward_to_ip,
    input logic [7:0]  o_ttl_out
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_status)
            && $stable(o_forward_to_ip) && $stable(o_ttl_out)))
        else $error("Result word changed while stalled.");

    a_busy_after_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_action) |=> !o_in_ready)
        else $error("Ready stayed high after a forward word was taken.");

    a_expired_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == STAT_EXPIRED)) |->
            (o_ttl_out == 8'd0 && o_egress_interface == 4'd0 && o_forward_to_ip == 32'd0))
        else $error("Expired result carries nonzero fields.");

    a_no_route_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == STAT_NO_ROUTE)) |->
            (o_egress_interface == 4'd0 && o_forward_to_ip == 32'd0 && o_ttl_out != 8'd0))
        else $error("No-route result fields are wrong.");

    a_live_ttl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == STAT_FORWARDED || o_status == STAT_BAD_IFACE)) |->
            (o_ttl_out != 8'd0))
        else $error("Routed result has a zero TTL.");

endmodule

bind ipv4_longest_prefix_router iplpr_checker u_iplpr_checker (.*);
